@@ rtl/krt_pkg.sv @@
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants for the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

   localparam int TableDepthDefault = 16;
   localparam int MaxResults = 16;

   typedef enum logic [2:0] {
      FUNC_INSERT = 3'd0,
      FUNC_DELETE = 3'd1,
      FUNC_LOOKUP = 3'd2,
      FUNC_SORT   = 3'd3,
      FUNC_LIST   = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [30:0] key_serial;
      logic [15:0] brand_code;
      logic [15:0] model_code;
      logic [23:0] price_value;
      logic [11:0] year_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot_index;
      logic [30:0] out_serial;
      logic [15:0] out_brand;
      logic [15:0] out_model;
      logic [23:0] out_price;
      logic [11:0] out_year;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [30:0] serial;
      logic [15:0] brand;
      logic [15:0] model;
      logic [23:0] price;
      logic [11:0] year;
   } rec_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_EMIT,
      S_LIST,
      S_LIST_END,
      S_SORT_RDI,
      S_SORT_LDI,
      S_SORT_CMP,
      S_SORT_WBI
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       clr_scan;
      logic       scan_rd;
      logic       rd_hit;
      logic       rd_i;
      logic       rd_j;
      logic       rd_jn;
      logic       ld_i;
      logic       inc_i;
      logic       set_j;
      logic       inc_j;
      logic       wr_insert;
      logic       clr_used;
      logic       wr_j;
      logic       wb_i;
      logic       cnt_inc;
      logic       emit_rec;
      logic       emit_ins;
      logic       emit_empty;
      logic       emit_last;
      status_type emit_status;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic       scan_end;
      logic       found_free;
      logic       found_key;
      logic       chk_hit;
      logic       chk_last;
      logic       list_cap;
      logic       list_none;
      logic       i_end;
      logic       j_end;
      logic       need_swap;
      logic [2:0] func;
   } stat_type;

endpackage

@@ rtl/keyed_record_table.sv @@
// ----------------------------------------------------------------------------
// keyed_record_table
// Fixed-slot record table keyed by serial, with insert, delete, lookup,
// selection sort and list.
// ----------------------------------------------------------------------------
// Usage
//   A transaction is taken when start is high and busy is low; req_data holds
//   the function code and the record fields. Results leave on rsp_data with a
//   one-cycle rsp_valid strobe; rsp_data.last marks the final result.
//   The receiver cannot stall, so every result must be taken when shown.
// Timing
//   Insert, delete and lookup scan one slot a cycle through the registered
//   read port, then decide in S_DECIDE; the result is registered, and a
//   stored record that is returned is first read back in S_EMIT.
//   The next transaction can be taken in the result cycle.
//   List scans the same way; records leave as they are found, and the empty
//   status leaves at the end of the scan when none is found.
//   Sort reads slot i, compares it with each later slot, swapping as needed,
//   writes it back, and shows its result in the cycle after the last write-back.
//   Unknown function codes are taken and dropped with no result.
// Reset
//   Synchronous reset marks every slot free; stored records are not cleared.
// ----------------------------------------------------------------------------
module keyed_record_table
   import krt_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // sequencer and table
   krt_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule

@@ rtl/krt_datapath.sv @@
// ----------------------------------------------------------------------------
// krt_datapath
// Record memory, used bits, scan and sort indices, and result register.
// ----------------------------------------------------------------------------
module krt_datapath
   import krt_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  ctrl_type ctrl,
   output stat_type stat,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(MaxResults + 1);

   rec_type mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] used_ff;
   logic [TABLE_DEPTH-1:0] used_above;
   req_type req_ff;
   rec_type ins_rec;
   logic [IW:0] scan_ff;
   logic [IW-1:0] scan_idx, rd_addr, wr_addr;
   logic [IW-1:0] chk_ff, i_ff, j_ff, free_ff, hit_ff;
   logic chk_vld_ff;
   logic found_free_ff, found_key_ff;
   rec_type rd_ff, ri_ff, wr_data;
   logic ui_ff;
   logic [CW-1:0] cnt_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   assign scan_idx = scan_ff[IW-1:0];
   assign ins_rec  = {req_ff.key_serial, req_ff.brand_code, req_ff.model_code,
                      req_ff.price_value, req_ff.year_value};

   // read address mux
   always_comb begin
      rd_addr = scan_idx;
      if (ctrl.rd_hit) rd_addr = hit_ff;
      else if (ctrl.rd_i) rd_addr = i_ff;
      else if (ctrl.rd_j) rd_addr = j_ff;
      else if (ctrl.rd_jn) rd_addr = j_ff + 1'b1;
   end

   // write address and data mux, one write a cycle
   always_comb begin
      wr_addr = i_ff;
      wr_data = ri_ff;
      if (ctrl.wr_insert) begin
         wr_addr = free_ff;
         wr_data = ins_rec;
      end else if (ctrl.wr_j) begin
         wr_addr = j_ff;
      end
   end

   // record memory
   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (ctrl.wr_insert || ctrl.wr_j || ctrl.wb_i) mem[wr_addr] <= wr_data;
   end

   // used bits
   always_ff @(posedge clock) begin
      if (reset) used_ff <= '0;
      else if (ctrl.wr_insert) used_ff[free_ff] <= 1'b1;
      else if (ctrl.clr_used) used_ff[hit_ff] <= 1'b0;
      else if (ctrl.wr_j) used_ff[j_ff] <= ui_ff;
      else if (ctrl.wb_i) used_ff[i_ff] <= ui_ff;
   end

   // slot check comes in the cycle after the read
   always_ff @(posedge clock) begin
      if (reset) chk_vld_ff <= 1'b0;
      else chk_vld_ff <= ctrl.scan_rd;
   end

   // request, scan position, first free and first matching slot
   always_ff @(posedge clock) begin
      if (ctrl.load_req) req_ff <= req_data;
      if (ctrl.scan_rd) chk_ff <= scan_idx;
      else if (ctrl.rd_hit) chk_ff <= hit_ff;
      if (ctrl.clr_scan) begin
         scan_ff <= '0;
         found_free_ff <= 1'b0;
         found_key_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (ctrl.scan_rd) scan_ff <= scan_ff + 1'b1;
         if (ctrl.cnt_inc) cnt_ff <= cnt_ff + 1'b1;
         if (chk_vld_ff && !used_ff[chk_ff] && !found_free_ff) begin
            found_free_ff <= 1'b1;
            free_ff <= chk_ff;
         end
         if (chk_vld_ff && used_ff[chk_ff] && rd_ff.serial == req_ff.key_serial
             && !found_key_ff) begin
            found_key_ff <= 1'b1;
            hit_ff <= chk_ff;
         end
      end
   end

   // sort indices; slot i is held in ri_ff while j runs
   always_ff @(posedge clock) begin
      if (ctrl.clr_scan) i_ff <= '0;
      else if (ctrl.inc_i) i_ff <= i_ff + 1'b1;
      if (ctrl.set_j) j_ff <= i_ff + 1'b1;
      else if (ctrl.inc_j) j_ff <= j_ff + 1'b1;
      if (ctrl.ld_i) begin
         ri_ff <= rd_ff;
         ui_ff <= used_ff[i_ff];
      end else if (ctrl.wr_j) begin
         ri_ff <= rd_ff;
         ui_ff <= used_ff[j_ff];
      end
   end

   // status toward the controller
   assign used_above = used_ff >> chk_ff;

   always_comb begin
      stat.scan_end   = (scan_ff == (IW+1)'(TABLE_DEPTH));
      stat.found_free = found_free_ff;
      stat.found_key  = found_key_ff;
      stat.chk_hit    = chk_vld_ff && used_ff[chk_ff];
      stat.chk_last   = !(|used_above[TABLE_DEPTH-1:1]) ||
                        (cnt_ff == CW'(MaxResults - 1));
      stat.list_cap   = (cnt_ff == CW'(MaxResults));
      stat.list_none  = (cnt_ff == '0);
      stat.i_end      = (i_ff == IW'(TABLE_DEPTH - 2));
      stat.j_end      = (j_ff == IW'(TABLE_DEPTH - 1));
      stat.need_swap  = ui_ff ? (used_ff[j_ff] && ri_ff.serial > rd_ff.serial)
                              : used_ff[j_ff];
      stat.func       = req_ff.func;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= ctrl.emit_rec | ctrl.emit_ins | ctrl.emit_empty;
      rsp_ff.status <= ctrl.emit_status;
      rsp_ff.last   <= ctrl.emit_last;
      if (ctrl.emit_ins) begin
         rsp_ff.slot_index <= 4'(free_ff);
         {rsp_ff.out_serial, rsp_ff.out_brand, rsp_ff.out_model,
          rsp_ff.out_price, rsp_ff.out_year} <= ins_rec;
      end else if (ctrl.emit_rec) begin
         rsp_ff.slot_index <= 4'(chk_ff);
         {rsp_ff.out_serial, rsp_ff.out_brand, rsp_ff.out_model,
          rsp_ff.out_price, rsp_ff.out_year} <= rd_ff;
      end else begin
         rsp_ff.slot_index <= '0;
         rsp_ff.out_serial <= '0;
         rsp_ff.out_brand  <= '0;
         rsp_ff.out_model  <= '0;
         rsp_ff.out_price  <= '0;
         rsp_ff.out_year   <= '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/krt_control.sv @@
// ----------------------------------------------------------------------------
// krt_control
// Sequencer for insert, delete, lookup, sort and list.
// ----------------------------------------------------------------------------
module krt_control
   import krt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [2:0] req_func,
   input  stat_type   stat,
   output logic       busy,
   output ctrl_type   ctrl
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // next state and commands
   // scan: slot k is read, and checked in the cycle after
   always_comb begin
      state_in = state_ff;
      ctrl = '0;
      busy = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctrl.load_req = 1'b1;
               ctrl.clr_scan = 1'b1;
               case (req_func)
                  FUNC_INSERT, FUNC_DELETE, FUNC_LOOKUP: state_in = S_SCAN;
                  FUNC_SORT: state_in = S_SORT_RDI;
                  FUNC_LIST: state_in = S_LIST;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (!stat.scan_end) ctrl.scan_rd = 1'b1;
            else state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_IDLE;
            ctrl.emit_last = 1'b1;
            if (stat.func == FUNC_INSERT) begin
               if (!stat.found_free) begin
                  ctrl.emit_empty = 1'b1;
                  ctrl.emit_status = ST_FULL;
               end else if (stat.found_key) begin
                  ctrl.rd_hit = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  ctrl.wr_insert = 1'b1;
                  ctrl.emit_ins = 1'b1;
                  ctrl.emit_status = ST_OK;
               end
            end else if (!stat.found_key) begin
               ctrl.emit_empty = 1'b1;
               ctrl.emit_status = ST_NOT_FOUND;
            end else begin
               ctrl.rd_hit = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // found record now read back
            ctrl.emit_rec = 1'b1;
            ctrl.emit_last = 1'b1;
            ctrl.emit_status = (stat.func == FUNC_INSERT) ? ST_DUPLICATE : ST_OK;
            ctrl.clr_used = (stat.func == FUNC_DELETE);
            state_in = S_IDLE;
         end
         S_LIST: begin
            if (stat.chk_hit && !stat.list_cap) begin
               ctrl.emit_rec = 1'b1;
               ctrl.cnt_inc = 1'b1;
               ctrl.emit_last = stat.chk_last;
               ctrl.emit_status = ST_OK;
            end
            if (!stat.scan_end) ctrl.scan_rd = 1'b1;
            else state_in = S_LIST_END;
         end
         S_LIST_END: begin
            if (stat.list_none) begin
               ctrl.emit_empty = 1'b1;
               ctrl.emit_last = 1'b1;
               ctrl.emit_status = ST_EMPTY;
            end
            state_in = S_IDLE;
         end
         S_SORT_RDI: begin
            ctrl.rd_i = 1'b1;
            ctrl.set_j = 1'b1;
            state_in = S_SORT_LDI;
         end
         S_SORT_LDI: begin
            ctrl.ld_i = 1'b1;
            ctrl.rd_j = 1'b1;
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            // one pair a cycle; slot i lives in a register until write-back
            if (stat.need_swap) ctrl.wr_j = 1'b1;
            if (!stat.j_end) begin
               ctrl.inc_j = 1'b1;
               ctrl.rd_jn = 1'b1;
            end else begin
               state_in = S_SORT_WBI;
            end
         end
         S_SORT_WBI: begin
            ctrl.wb_i = 1'b1;
            if (!stat.i_end) begin
               ctrl.inc_i = 1'b1;
               state_in = S_SORT_RDI;
            end else begin
               ctrl.emit_empty = 1'b1;
               ctrl.emit_last = 1'b1;
               ctrl.emit_status = ST_OK;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

@@ rtl/krt_core.sv @@
// ----------------------------------------------------------------------------
// krt_core
// Controller and datapath joined by command and status signals.
// ----------------------------------------------------------------------------
module krt_core
   import krt_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   ctrl_type ctrl;
   stat_type stat;

   // sequencer
   krt_control u_control (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_func(req_data.func),
      .stat    (stat),
      .busy    (busy),
      .ctrl    (ctrl)
   );

   // table storage and result register
   krt_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctrl     (ctrl),
      .stat     (stat),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule

@@ rtl/krt_checker.sv @@
// ----------------------------------------------------------------------------
// krt_checker
// Port-level checks on the keyed record table.
// ----------------------------------------------------------------------------
module krt_checker
   import krt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input req_type req_data,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // no result in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");

   // busy is low out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !busy)
      else $error("busy after reset");

   // status codes stay in range
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_EMPTY)
      else $error("bad status");

   // a transaction with a known function makes the block busy
   a_take: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.func <= FUNC_LIST) |=> busy)
      else $error("transaction not taken");

endmodule

bind keyed_record_table krt_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .req_data (req_data),
   .busy     (busy),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data)
);
